FILE: sv/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

  // Parser phase of the front end
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CLOSED  = 3'd5
  } phase_e;

  // Result kind as seen on the output port
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  localparam logic [3:0] OPCODE_MASK = 4'hF;
  localparam logic [3:0] OP_TEXT     = 4'h1;
  localparam logic [3:0] OP_CLOSE    = 4'h8;
  localparam logic [6:0] LEN7_MASK   = 7'h7F;
  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  // One command from front to back: raw byte, its mask key byte, kind, last flag
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    kind_e      kind;
    logic       last;
  } wsd_cmd_t;

endpackage

FILE: sv/websocket_frame_deframer.sv
// Top level of the WebSocket client-frame deframer and unmasker.
// Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | sink      | in_valid_i/in_stall_o  | in_byte_i
//  out     | source    | out_valid_o/out_stall_i| out_byte_o, out_kind_o, frame_last_o
//
// One byte is taken per clock while the queue is not full; the parser updates
// its state in the cycle of acceptance, the matching result is written into
// the queue at the accepting edge and then loaded into the output register.
// Sustained rate is one item per cycle while the output is not stalled, set by
// the parser step and the length-counter decrement.
// Reset (rst_ni low, asynchronous) returns the parser to the first header
// byte, clears the mask key and empties the queue and output register.
// The input stalls only while the two-entry queue is full, so an output
// stall reaches the input after the output register and queue fill up.
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_kind_o,
  output logic       frame_last_o
);

  // Front to queue
  logic     q_push;
  wsd_cmd_t q_push_cmd;
  logic     q_full;
  // Queue to back
  logic     q_pop;
  logic     q_empty;
  wsd_cmd_t q_head;

  // Parse headers, track length and mask key, classify each byte
  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_byte_i (in_byte_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_push_cmd)
  );

  // Decouple parser from output backpressure
  wsd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(q_push_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_o    (q_head)
  );

  // Unmask and hold the result until taken
  wsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_kind_o  (out_kind_o),
    .frame_last_o(frame_last_o)
  );

endmodule

FILE: sv/wsd_front.sv
// Front end of the deframer: header, extended length and mask parser.
// Depends on wsd_pkg; pushes result commands into wsd_queue.
module wsd_front
  import wsd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output wsd_cmd_t q_cmd_o
);

  phase_e                 phase_q, phase_d;
  logic                   is_text_q, is_text_d;
  logic [3:0]             ext_left_q, ext_left_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;
  logic [7:0]             key_q [4];
  logic [7:0]             key_d [4];
  logic [1:0]             idx_q, idx_d;

  logic       accept;
  logic [3:0] opcode;
  logic [6:0] len7;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign opcode     = in_byte_i[3:0] & OPCODE_MASK;
  assign len7       = in_byte_i[6:0] & LEN7_MASK;

  always_comb begin
    phase_d    = phase_q;
    is_text_d  = is_text_q;
    ext_left_d = ext_left_q;
    remain_d   = remain_q;
    key_d      = key_q;
    idx_d      = idx_q;
    q_push_o   = 1'b0;
    q_cmd_o    = '{data: 8'd0, key: 8'd0, kind: KIND_DATA, last: 1'b1};
    if (accept) begin
      unique case (phase_q)
        PH_HDR0: begin
          if (opcode == OP_CLOSE) begin
            phase_d      = PH_CLOSED;
            q_push_o     = 1'b1;
            q_cmd_o.kind = KIND_CLOSE;
          end else begin
            is_text_d = (opcode == OP_TEXT);
            phase_d   = PH_HDR1;
          end
        end
        PH_HDR1: begin
          idx_d    = 2'd0;
          remain_d = '0;
          priority if (len7 == LEN7_EXT16) begin
            ext_left_d = EXT16_BYTES;
            phase_d    = PH_EXT;
          end else if (len7 == LEN7_EXT64) begin
            ext_left_d = EXT64_BYTES;
            phase_d    = PH_EXT;
          end else begin
            ext_left_d = 4'd0;
            remain_d   = {{(LENGTH_BITS-7){1'b0}}, len7};
            phase_d    = PH_MASK;
          end
        end
        PH_EXT: begin
          // Shift in big-endian; bits above LENGTH_BITS fall off
          remain_d   = {remain_q[LENGTH_BITS-9:0], in_byte_i};
          ext_left_d = ext_left_q - 4'd1;
          if (ext_left_q == 4'd1) begin
            phase_d = PH_MASK;
          end
        end
        PH_MASK: begin
          key_d[idx_q] = in_byte_i;
          idx_d        = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            if (remain_q == '0) begin
              phase_d = PH_HDR0;
              if (is_text_q) begin
                q_push_o     = 1'b1;
                q_cmd_o.kind = KIND_EMPTY;
              end
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          idx_d    = idx_q + 2'd1;
          remain_d = remain_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
          if (remain_q == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
            phase_d = PH_HDR0;
          end
          q_push_o     = is_text_q;
          q_cmd_o.data = in_byte_i;
          q_cmd_o.key  = key_q[idx_q];
          q_cmd_o.kind = KIND_DATA;
          q_cmd_o.last = (remain_q == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
        end
        PH_CLOSED: begin
          // drop everything until reset
        end
        default: begin
          phase_d = PH_CLOSED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      is_text_q  <= 1'b0;
      ext_left_q <= 4'd0;
      remain_q   <= '0;
      key_q      <= '{default: 8'd0};
      idx_q      <= 2'd0;
    end else begin
      phase_q    <= phase_d;
      is_text_q  <= is_text_d;
      ext_left_q <= ext_left_d;
      remain_q   <= remain_d;
      key_q      <= key_d;
      idx_q      <= idx_d;
    end
  end

endmodule

FILE: sv/wsd_queue.sv
// Two-entry command queue between parser front end and output back end.
// Depends on wsd_pkg for the command type and depth.
module wsd_queue
  import wsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  wsd_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output wsd_cmd_t head_o
);

  localparam logic [QPTR_W:0] DepthCnt = (QPTR_W+1)'(QUEUE_DEPTH);
  localparam logic [QPTR_W:0] CntOne   = (QPTR_W+1)'(1);

  wsd_cmd_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntOne;
        2'b01:   count_q <= count_q - CntOne;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: sv/wsd_back.sv
// Back end of the deframer: unmasks queued commands into the output register.
// Depends on wsd_pkg; drains wsd_queue.
module wsd_back
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  wsd_cmd_t   q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_kind_o,
  output logic       frame_last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  kind_e      kind_q;
  logic       last_q;

  // Load a new result when the register is empty or being taken
  assign q_pop_o = ~q_empty_i & (~valid_q | ~out_stall_i);
  assign valid_d = q_pop_o | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q <= q_head_i.data ^ q_head_i.key;
      kind_q <= q_head_i.kind;
      last_q <= q_head_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign out_kind_o   = kind_q;
  assign frame_last_o = last_q;

endmodule
